>>> hw/rtl/ait_pkg.sv
// ----------------------------------------------------------------------------
// Adaptive interpolated table package
// Shared constants, codes and types for the grid lookup and its divider.
// ----------------------------------------------------------------------------
package ait_pkg;

  localparam int MaxStepsDef = 15;
  localparam int ValueBits   = 32;
  localparam int FracBits    = 16;
  localparam int CfgIdxBits  = 3;

  localparam logic [1:0] REQ_QUERY = 2'd0;
  localparam logic [1:0] REQ_LEARN = 2'd1;
  localparam logic [1:0] REQ_FILL  = 2'd2;

  localparam logic [CfgIdxBits-1:0] CFG_X_MIN      = 3'd0;
  localparam logic [CfgIdxBits-1:0] CFG_X_SPAN     = 3'd1;
  localparam logic [CfgIdxBits-1:0] CFG_X_STEPS    = 3'd2;
  localparam logic [CfgIdxBits-1:0] CFG_Y_MIN      = 3'd3;
  localparam logic [CfgIdxBits-1:0] CFG_Y_SPAN     = 3'd4;
  localparam logic [CfgIdxBits-1:0] CFG_Y_STEPS    = 3'd5;
  localparam logic [CfgIdxBits-1:0] CFG_LEARN_RATE = 3'd6;

  // operands of one coordinate division
  typedef struct packed {
    logic signed [31:0] coord;
    logic signed [31:0] mn;
    logic        [30:0] span;
    logic        [3:0]  steps;
  } div_req_t;

endpackage

>>> hw/rtl/ait_div.sv
// ----------------------------------------------------------------------------
// Coordinate divider
// Computes min(steps*(coord-min)*2^16/span, steps*2^16), or zero when coord
// <= min or steps is zero; one quotient bit per cycle by restoring division.
// ----------------------------------------------------------------------------
module ait_div #(
  parameter int QW = 20
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  ait_pkg::div_req_t req_i,
  output logic              done_o,
  output logic [QW-1:0]     q_o
);
  import ait_pkg::*;

  localparam int CW = $clog2(QW + 1);

  logic signed [32:0] diff;
  logic        [30:0] span_eff;
  logic        [35:0] prod;
  logic        [51:0] num;
  logic        [51:0] pre;
  logic        [QW-1:0] top;
  logic               trivial, ovf;

  logic          run_q, run_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [30:0]   rem_q, rem_d;
  logic [QW-1:0] low_q, low_d;
  logic [QW-1:0] acc_q, acc_d;
  logic [QW-1:0] top_q, top_d;
  logic [QW-1:0] q_q, q_d;
  logic          done_q, done_d;
  logic [30:0]   span_eff_q, span_eff_d;
  logic [31:0]   rem_sh;
  logic          ge;
  logic [QW-1:0] acc_nx;

  assign diff     = 33'(req_i.coord) - 33'(req_i.mn);
  assign span_eff = (req_i.span == '0) ? 31'd1 : req_i.span;
  assign prod     = 36'(diff[31:0]) * 36'(req_i.steps);
  assign num      = {prod, 16'd0};
  assign pre      = num >> QW;
  assign top      = QW'({req_i.steps, 16'd0});
  assign trivial  = (req_i.steps == '0) || (diff <= 33'sd0);
  assign ovf      = pre >= 52'(span_eff);

  assign rem_sh = {rem_q, low_q[QW-1]};
  assign ge     = rem_sh >= 32'(span_eff_q);
  assign acc_nx = {acc_q[QW-2:0], ge};

  always_comb begin
    run_d      = run_q;
    cnt_d      = cnt_q;
    rem_d      = rem_q;
    low_d      = low_q;
    acc_d      = acc_q;
    top_d      = top_q;
    q_d        = q_q;
    span_eff_d = span_eff_q;
    done_d     = 1'b0;
    if (start_i) begin
      top_d      = top;
      span_eff_d = span_eff;
      if (trivial) begin
        q_d    = '0;
        done_d = 1'b1;
      end else if (ovf) begin
        q_d    = top;
        done_d = 1'b1;
      end else begin
        run_d = 1'b1;
        cnt_d = CW'(QW);
        rem_d = pre[30:0];
        low_d = num[QW-1:0];
        acc_d = '0;
      end
    end else if (run_q) begin
      rem_d = ge ? 31'(rem_sh - 32'(span_eff_q)) : rem_sh[30:0];
      low_d = {low_q[QW-2:0], 1'b0};
      acc_d = acc_nx;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
        q_d    = (acc_nx > top_q) ? top_q : acc_nx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q      <= rem_d;
    low_q      <= low_d;
    acc_q      <= acc_d;
    top_q      <= top_d;
    q_q        <= q_d;
    span_eff_q <= span_eff_d;
  end

  assign done_o = done_q;
  assign q_o    = q_q;

endmodule

>>> hw/rtl/adaptive_interpolated_table.sv
// ----------------------------------------------------------------------------
// Adaptive interpolated table
// Two-axis Q16.16 grid read by bilinear interpolation and trained by an LMS
// step; a fill request sets every entry at once.
//
//  Channel   Signals                                      Direction
//  request   start, busy (out), req_type_i, coord_x_i,    in
//            coord_y_i, target_value_i
//  result    result_valid_o, predicted_o                  out
//  config    cfg_valid_i, cfg_ready_o (out), cfg_index_i, in
//            cfg_data_i
//
// A fill completes without raising busy. A query keeps busy high while two
// bit-serial coordinate divisions (QW = 20 for 15 steps) run through one
// shared divider, shorter when a division is trivial or clamps; a learn adds
// the four corner read-modify-writes on the single table port. The result
// strobe is high for one cycle as busy falls, or after a fill. Reset clears
// the table to zero through per-entry valid bits.
// ----------------------------------------------------------------------------
module adaptive_interpolated_table #(
  parameter int MAX_STEPS = ait_pkg::MaxStepsDef
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [1:0]                            req_type_i,
  input  logic signed [31:0]                    coord_x_i,
  input  logic signed [31:0]                    coord_y_i,
  input  logic signed [31:0]                    target_value_i,
  output logic                                  result_valid_o,
  output logic signed [ait_pkg::ValueBits-1:0]  predicted_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [ait_pkg::CfgIdxBits-1:0]        cfg_index_i,
  input  logic [31:0]                           cfg_data_i
);
  import ait_pkg::*;

  localparam int DIM   = MAX_STEPS + 1;
  localparam int DEPTH = DIM * DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = $clog2(DIM);
  localparam int QW    = IW + FracBits;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIVX = 3'd1;
  localparam logic [2:0] S_DIVY = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_CRD  = 3'd5;
  localparam logic [2:0] S_CWR  = 3'd6;

  localparam logic signed [34:0] VMax = 35'((64'sd1 <<< (ValueBits - 1)) - 1);
  localparam logic signed [34:0] VMin = -VMax - 35'sd1;

  // configuration
  logic signed [31:0] x_min_q, y_min_q;
  logic [30:0]        x_span_q, y_span_q;
  logic [3:0]         x_steps_q, y_steps_q;
  logic [15:0]        rate_q;

  logic [3:0] xs_c, ys_c;
  assign xs_c = (32'(x_steps_q) > MAX_STEPS) ? 4'(MAX_STEPS) : x_steps_q;
  assign ys_c = (32'(y_steps_q) > MAX_STEPS) ? 4'(MAX_STEPS) : y_steps_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_min_q   <= '0;
      x_span_q  <= 31'd65536;
      x_steps_q <= 4'd15;
      y_min_q   <= '0;
      y_span_q  <= 31'd65536;
      y_steps_q <= 4'd15;
      rate_q    <= 16'd32768;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_X_MIN:      x_min_q   <= cfg_data_i;
        CFG_X_SPAN:     x_span_q  <= cfg_data_i[30:0];
        CFG_X_STEPS:    x_steps_q <= cfg_data_i[3:0];
        CFG_Y_MIN:      y_min_q   <= cfg_data_i;
        CFG_Y_SPAN:     y_span_q  <= cfg_data_i[30:0];
        CFG_Y_STEPS:    y_steps_q <= cfg_data_i[3:0];
        CFG_LEARN_RATE: rate_q    <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // control
  logic [2:0] state_q, state_d;
  logic [3:0] cnt_q, cnt_d;
  logic       learn_q, learn_d;
  logic signed [31:0] cy_q, tgt_q;
  logic signed [31:0] fill_q;
  logic       res_valid_q, res_valid_d;
  logic signed [31:0] predicted_q, predicted_d;

  // divider
  div_req_t        dreq;
  logic            div_start, div_done;
  logic [QW-1:0]   div_q;

  assign div_start = ((state_q == S_IDLE) && start && (req_type_i != REQ_FILL))
                   || ((state_q == S_DIVX) && div_done);

  always_comb begin
    if (state_q == S_IDLE) begin
      dreq = '{coord: coord_x_i, mn: x_min_q, span: x_span_q, steps: xs_c};
    end else begin
      dreq = '{coord: cy_q, mn: y_min_q, span: y_span_q, steps: ys_c};
    end
  end

  ait_div #(.QW(QW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .req_i   (dreq),
    .done_o  (div_done),
    .q_o     (div_q)
  );

  // grid indexes
  logic [IW-1:0] ix_q, jx_q, iy_q, jy_q;
  logic [15:0]   fx_q, fy_q;
  logic [IW-1:0] di, dj;
  logic [3:0]    dsteps;

  assign dsteps = (state_q == S_DIVX) ? xs_c : ys_c;
  assign di     = div_q[QW-1:FracBits];
  assign dj     = (32'(di) < 32'(dsteps)) ? IW'(32'(di) + 1) : IW'(dsteps);

  logic [AW-1:0] addr [4];
  assign addr[0] = AW'(32'(ix_q) * DIM + 32'(iy_q));
  assign addr[1] = AW'(32'(ix_q) * DIM + 32'(jy_q));
  assign addr[2] = AW'(32'(jx_q) * DIM + 32'(iy_q));
  assign addr[3] = AW'(32'(jx_q) * DIM + 32'(jy_q));

  // table memory with valid bits
  logic signed [ValueBits-1:0] mem [DEPTH];
  logic [DEPTH-1:0]            vld_q;
  logic signed [ValueBits-1:0] rd_q;
  logic                        rv_q;
  logic [AW-1:0]               raddr;
  logic                        we;
  logic signed [ValueBits-1:0] wdata;
  logic signed [ValueBits-1:0] rval;
  logic                        fill_go;

  assign fill_go = (state_q == S_IDLE) && start && (req_type_i == REQ_FILL);

  always_comb begin
    raddr = addr[0];
    if (state_q == S_RD) begin
      raddr = addr[cnt_q[1:0]];
    end else if (state_q == S_CRD || state_q == S_CWR) begin
      raddr = addr[cnt_q[1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[raddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rv_q   <= 1'b0;
      fill_q <= '0;
    end else begin
      rv_q <= vld_q[raddr];
      if (fill_go) begin
        vld_q  <= '0;
        fill_q <= target_value_i;
      end else if (we) begin
        vld_q[raddr] <= 1'b1;
      end
    end
  end

  assign rval = rv_q ? rd_q : fill_q;

  // shared multiplier
  logic signed [31:0] c_q [4];
  logic signed [31:0] row_i_q, row_j_q, pred_q;
  logic signed [33:0] delta_q, dxi_q, dxj_q, inc_q;
  logic signed [33:0] ma;
  logic        [16:0] mb;
  logic               madd;
  logic signed [50:0] prod;
  logic signed [51:0] acc_q, sum, rnd;
  logic        [16:0] wx0, wy0;
  logic signed [32:0] err;
  logic signed [34:0] wsum;

  assign wx0 = 17'd65536 - 17'(fx_q);
  assign wy0 = 17'd65536 - 17'(fy_q);
  assign err = 33'(tgt_q) - 33'(pred_q);

  always_comb begin
    ma   = 34'(c_q[0]);
    mb   = wy0;
    madd = 1'b0;
    if (state_q == S_CRD) begin
      ma = cnt_q[1] ? dxj_q : dxi_q;
      mb = cnt_q[0] ? 17'(fy_q) : wy0;
    end else begin
      case (cnt_q)
        4'd1: begin ma = 34'(c_q[1]); mb = 17'(fy_q); madd = 1'b1; end
        4'd2: begin ma = 34'(c_q[2]); mb = wy0; end
        4'd3: begin ma = 34'(c_q[3]); mb = 17'(fy_q); madd = 1'b1; end
        4'd4: begin ma = 34'(row_i_q); mb = wx0; end
        4'd5: begin ma = 34'(row_j_q); mb = 17'(fx_q); madd = 1'b1; end
        4'd6: begin ma = 34'(err); mb = 17'(rate_q); end
        4'd7: begin ma = delta_q; mb = wx0; end
        4'd8: begin ma = delta_q; mb = 17'(fx_q); end
        default: ;
      endcase
    end
  end

  assign prod = 51'(ma) * 51'($signed({1'b0, mb}));
  assign sum  = madd ? acc_q + 52'(prod) : 52'(prod);
  assign rnd  = (sum + 52'sd32768) >>> FracBits;

  assign wsum  = 35'(rval) + 35'(inc_q);
  assign wdata = (wsum > VMax) ? ValueBits'(VMax) :
                 (wsum < VMin) ? ValueBits'(VMin) : wsum[ValueBits-1:0];
  assign we    = (state_q == S_CWR);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    learn_d     = learn_q;
    res_valid_d = 1'b0;
    predicted_d = predicted_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          learn_d = (req_type_i == REQ_LEARN);
          if (req_type_i == REQ_FILL) begin
            res_valid_d = 1'b1;
            predicted_d = '0;
          end else begin
            state_d = S_DIVX;
          end
        end
      end
      S_DIVX: begin
        if (div_done) begin
          state_d = S_DIVY;
        end
      end
      S_DIVY: begin
        if (div_done) begin
          state_d = S_RD;
          cnt_d   = '0;
        end
      end
      S_RD: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 4'd4) begin
          state_d = S_MUL;
          cnt_d   = '0;
        end
      end
      S_MUL: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 4'd5 && !learn_q) begin
          state_d     = S_IDLE;
          res_valid_d = 1'b1;
          predicted_d = rnd[31:0];
        end else if (cnt_q == 4'd8) begin
          state_d = S_CRD;
          cnt_d   = '0;
        end
      end
      S_CRD: begin
        state_d = S_CWR;
      end
      S_CWR: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 4'd3) begin
          state_d     = S_IDLE;
          res_valid_d = 1'b1;
          predicted_d = pred_q;
        end else begin
          state_d = S_CRD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      learn_q     <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      learn_q     <= learn_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    predicted_q <= predicted_d;
    if (state_q == S_IDLE && start) begin
      cy_q  <= coord_y_i;
      tgt_q <= target_value_i;
    end
    if (state_q == S_DIVX && div_done) begin
      ix_q <= di;
      jx_q <= dj;
      fx_q <= div_q[FracBits-1:0];
    end
    if (state_q == S_DIVY && div_done) begin
      iy_q <= di;
      jy_q <= dj;
      fy_q <= div_q[FracBits-1:0];
    end
    if (state_q == S_RD && cnt_q != 4'd0) begin
      c_q[2'(cnt_q - 4'd1)] <= rval;
    end
    if (state_q == S_MUL) begin
      acc_q <= sum;
      case (cnt_q)
        4'd1: row_i_q <= rnd[31:0];
        4'd3: row_j_q <= rnd[31:0];
        4'd5: pred_q  <= rnd[31:0];
        4'd6: delta_q <= rnd[33:0];
        4'd7: dxi_q   <= rnd[33:0];
        4'd8: dxj_q   <= rnd[33:0];
        default: ;
      endcase
    end
    if (state_q == S_CRD) begin
      inc_q <= rnd[33:0];
    end
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = res_valid_q;
  assign predicted_o    = predicted_q;

endmodule
